// File: src/sawc_pkg.sv
package sawc_pkg;
    localparam int ADDRESS_BITS_DEF = 48;
    localparam int BLOCK_BYTES_DEF  = 64;
    localparam int NUM_SETS_DEF     = 256;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int FIELD_ADDR_W     = 48;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_INVAL = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_WAYS   = 1'b1;

    typedef struct packed {
        logic clear;    // clear the valid bits of one set per cycle
        logic lookup;   // register the set read and start the update
        logic commit;   // write the set back and load the result
    } sawc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic result_loaded;
    } sawc_status_t;
endpackage

// File: src/set_assoc_writeback_cache_tags.sv
// Channel  | Dir | tdata fields (low bit up)                 | tuser
// s_axis   | in  | mode[1:0], address[49:2]                  | none
// m_axis   | out | hit[0], victim_valid[1], victim_dirty[2], |
//          |     | victim_address[50:3]                      | none
//
// Every access reads the set's row from the tag memory into a register,
// then updates it and writes it back. One access is in flight at a time,
// so a new transaction is not accepted until the last one is written back.
// Reset (aresetn low, synchronous) is followed by a clearing pass that zeroes
// the valid bits of one set per cycle, every set in turn,
// during which s_tready stays low.
// A held result in the output register stalls the next acceptance only
// until it is taken; acceptance in the same cycle as the take is allowed.
module set_assoc_writeback_cache_tags #(
    parameter int ADDRESS_BITS = sawc_pkg::ADDRESS_BITS_DEF,
    parameter int BLOCK_BYTES  = sawc_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_SETS     = sawc_pkg::NUM_SETS_DEF,
    parameter int MAX_WAYS     = sawc_pkg::MAX_WAYS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mode[1:0], address[49:2]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // hit, victim_valid, victim_dirty, victim_address
);
    import sawc_pkg::*;

    logic       policy_reg;
    logic [3:0] ways_reg;

    // User writes configuration registers only while the block is idle; unenforced.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg <= 1'b0;
            ways_reg   <= 4'd8;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_POLICY: policy_reg <= cfg_wdata[0];
                REG_WAYS:   ways_reg   <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    sawc_cmd_t    cmd;
    sawc_status_t status;
    logic         out_busy;
    logic         hit, vv, vd;
    logic [FIELD_ADDR_W-1:0] va;

    sawc_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_busy,
        .cmd,
        .status
    );

    sawc_datapath #(
        .ADDRESS_BITS(ADDRESS_BITS), .BLOCK_BYTES(BLOCK_BYTES),
        .NUM_SETS(NUM_SETS), .MAX_WAYS(MAX_WAYS)
    ) u_dp (
        .aclk, .aresetn,
        .cfg_policy (policy_reg),
        .cfg_ways   (ways_reg),
        .in_mode    (s_tdata[1:0]),
        .in_address (s_tdata[49:2]),
        .cmd,
        .status,
        .out_taken  (m_tvalid && m_tready),
        .out_valid  (m_tvalid),
        .out_busy,
        .out_hit    (hit),
        .out_victim_valid (vv),
        .out_victim_dirty (vd),
        .out_victim_address (va)
    );

    assign m_tdata = {5'd0, va, vd, vv, hit};
endmodule

// File: src/sawc_ctrl.sv
module sawc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  out_busy,
    output sawc_pkg::sawc_cmd_t   cmd,
    input  sawc_pkg::sawc_status_t status
);
    import sawc_pkg::*;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_UPDATE} state_t;
    state_t state_reg;

    // Accept only in the idle state and when the result register is free or being drained.
    assign in_ready    = (state_reg == ST_IDLE) && !out_busy;
    assign cmd.clear   = (state_reg == ST_CLEAR);
    assign cmd.lookup  = in_valid && in_ready;
    assign cmd.commit  = (state_reg == ST_UPDATE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            case (state_reg)
                ST_CLEAR:  if (status.clear_done) state_reg <= ST_IDLE;
                ST_IDLE:   if (cmd.lookup) state_reg <= ST_UPDATE;
                ST_UPDATE: if (status.result_loaded) state_reg <= ST_IDLE;
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// File: src/sawc_datapath.sv
module sawc_datapath #(
    parameter int ADDRESS_BITS = sawc_pkg::ADDRESS_BITS_DEF,
    parameter int BLOCK_BYTES  = sawc_pkg::BLOCK_BYTES_DEF,
    parameter int NUM_SETS     = sawc_pkg::NUM_SETS_DEF,
    parameter int MAX_WAYS     = sawc_pkg::MAX_WAYS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_policy,
    input  logic [3:0]                     cfg_ways,
    input  logic [1:0]                     in_mode,
    input  logic [sawc_pkg::FIELD_ADDR_W-1:0] in_address,
    input  sawc_pkg::sawc_cmd_t            cmd,
    output sawc_pkg::sawc_status_t         status,
    input  logic                           out_taken,
    output logic                           out_valid,
    output logic                           out_busy,
    output logic                           out_hit,
    output logic                           out_victim_valid,
    output logic                           out_victim_dirty,
    output logic [sawc_pkg::FIELD_ADDR_W-1:0] out_victim_address
);
    import sawc_pkg::*;

    localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
    localparam int IDX_BITS = $clog2(NUM_SETS + 1) - 1;
    localparam int IDX_W    = (IDX_BITS > 0) ? IDX_BITS : 1;
    localparam int SETS_USED = 1 << IDX_BITS;
    localparam int EA_BITS  = (ADDRESS_BITS < FIELD_ADDR_W) ? ADDRESS_BITS : FIELD_ADDR_W;
    localparam int TAG_W    = (EA_BITS - OFF_BITS - IDX_BITS > 0) ?
                              EA_BITS - OFF_BITS - IDX_BITS : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W    = $clog2(MAX_WAYS + 1);

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              dirty;
        logic [RANK_W-1:0] rank;
    } way_t;

    // One row per set holds all ways; the valid bits sit in a second memory
    // that a clearing pass zeroes one set per cycle after reset.
    way_t [MAX_WAYS-1:0] mem [SETS_USED];
    logic [MAX_WAYS-1:0] valid_mem [SETS_USED];
    logic [IDX_W-1:0]    clr_idx_reg;

    way_t [MAX_WAYS-1:0] row_reg;
    logic [MAX_WAYS-1:0] rvalid_reg;
    logic [IDX_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [1:0]          mode_reg;

    logic [EA_BITS-1:0] ea;
    logic [IDX_W-1:0]   set_in;
    assign ea = in_address[EA_BITS-1:0];
    generate
        if (IDX_BITS > 0) begin : g_idx
            assign set_in = ea[OFF_BITS +: IDX_W];
        end else begin : g_noidx
            assign set_in = '0;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            row_reg  <= mem[set_in];
            set_reg  <= set_in;
            tag_reg  <= TAG_W'(ea >> (OFF_BITS + IDX_BITS));
            mode_reg <= in_mode;
        end
    end

    // Update of one set, done on the registered row.
    way_t [MAX_WAYS-1:0] row_n;
    logic [MAX_WAYS-1:0] v_n;
    logic [CNT_W-1:0] count, ways;
    logic found, evict, hit_n, vd_n, vv_n, ins_done;
    logic [RANK_W-1:0] fw, vw, drop_rank;
    logic drop;
    logic [TAG_W-1:0] vtag;

    always_comb begin
        row_n = row_reg; v_n = rvalid_reg;
        count = '0; found = 1'b0; fw = '0; vw = '0; evict = 1'b0;
        hit_n = 1'b0; vd_n = 1'b0; vv_n = 1'b0; vtag = '0;
        drop = 1'b0; drop_rank = '0; ins_done = 1'b0;
        ways = (cfg_ways == 4'd0) ? CNT_W'(1) :
               ({28'd0, cfg_ways} > MAX_WAYS) ? CNT_W'(MAX_WAYS) : CNT_W'(cfg_ways);
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (rvalid_reg[w]) begin
                count = count + 1'b1;
                if (!found && row_reg[w].tag == tag_reg) begin
                    found = 1'b1; fw = RANK_W'(w);
                end
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (rvalid_reg[w] && row_reg[w].rank == '0 && !evict) begin
                evict = 1'b1; vw = RANK_W'(w);
            end
        end
        if (mode_reg == MODE_INVAL) begin
            if (found) begin
                hit_n = 1'b1; vd_n = row_reg[fw].dirty;
                drop = 1'b1; drop_rank = row_reg[fw].rank; v_n[fw] = 1'b0;
            end
        end else if (mode_reg == MODE_READ || mode_reg == MODE_WRITE) begin
            if (found) begin
                hit_n = 1'b1;
                if (mode_reg == MODE_WRITE) row_n[fw].dirty = 1'b1;
                if (!cfg_policy) begin
                    drop = 1'b1; drop_rank = row_reg[fw].rank;
                end
            end else begin
                if (count >= ways && evict) begin
                    vv_n = 1'b1; vd_n = row_reg[vw].dirty; vtag = row_reg[vw].tag;
                    drop = 1'b1; drop_rank = '0; v_n[vw] = 1'b0;
                end
            end
        end
        if (drop) begin
            for (int w = 0; w < MAX_WAYS; w++)
                if (rvalid_reg[w] && row_reg[w].rank > drop_rank)
                    row_n[w].rank = row_reg[w].rank - 1'b1;
        end
        if ((mode_reg == MODE_READ || mode_reg == MODE_WRITE) && found && !cfg_policy)
            row_n[fw].rank = RANK_W'(count - 1'b1);
        if ((mode_reg == MODE_READ || mode_reg == MODE_WRITE) && !found) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                if (!v_n[w] && !ins_done) begin
                    ins_done = 1'b1; v_n[w] = 1'b1;
                    row_n[w].tag = tag_reg;
                    row_n[w].dirty = (mode_reg == MODE_WRITE);
                    row_n[w].rank = RANK_W'(count - CNT_W'(vv_n));
                end
            end
        end
    end

    // Tag, set and zero offset; the padding set bit drops out without index bits.
    logic [TAG_W+IDX_W+OFF_BITS-1:0] va_wide;
    assign va_wide = {vtag, set_reg, {OFF_BITS{1'b0}}} >> (IDX_W - IDX_BITS);
    logic [FIELD_ADDR_W-1:0] va;
    always_comb begin
        va = '0;
        va[EA_BITS-1:0] = va_wide[EA_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) mem[set_reg] <= row_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            valid_mem[clr_idx_reg] <= '0;
        end else if (cmd.commit) begin
            valid_mem[set_reg] <= v_n;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.lookup) rvalid_reg <= valid_mem[set_in];
    end

    logic out_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_taken) begin
            out_valid_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit            <= hit_n;
            out_victim_valid   <= vv_n;
            out_victim_dirty   <= vd_n;
            out_victim_address <= vv_n ? va : '0;
        end
    end
    assign out_valid = out_valid_reg;
    assign out_busy  = out_valid_reg && !out_taken;
    assign status.result_loaded = cmd.commit;
    assign status.clear_done    = cmd.clear && (clr_idx_reg == IDX_W'(SETS_USED - 1));
endmodule

// File: src/sawc_checker.sv
module sawc_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    // No acceptance right after one, while the access is still being updated.
    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("back-to-back accept");
    // Each accepted transaction yields a result once its update loads the output register.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid) else $error("missing result");
    // Victim address is zero unless a victim is reported.
    a_vaddr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[50:3] == '0) else $error("stray address");
    // A victim only arises on a miss.
    a_victim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> !m_tdata[0]) else $error("victim on hit");
endmodule

bind set_assoc_writeback_cache_tags sawc_props u_sawc_props (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
